### sv/skip_blend_downscaler_core_defines.svh
// Assertion macros for the skip-blend downscaler core.
`ifndef SKIP_BLEND_DOWNSCALER_CORE_DEFINES_SVH
`define SKIP_BLEND_DOWNSCALER_CORE_DEFINES_SVH

// Check a same-cycle implication on the core clock, idle during reset.
`define SKD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication in the next cycle on the core clock, idle during reset.
`define SKD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/skd_pkg.sv
// Shared types, register codes and pixel helpers for the skip-blend downscaler.
package skd_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        logic       frame_start;
        logic [7:0] pix_red;
        logic [7:0] pix_green;
        logic [7:0] pix_blue;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] out_x;
        logic [7:0] out_y;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } pix_out_t;

    typedef struct packed {
        logic [7:0] skip_x;
        logic [7:0] skip_y;
        logic [7:0] out_width;
        logic [7:0] out_height;
    } cfg_t;

    // Per-pixel decisions handed from the position tracker to the blend stage.
    typedef struct packed {
        logic       emit;
        logic       right;
        logic       down;
        logic [7:0] mx;
        logic [7:0] my;
    } tap_t;

    typedef struct packed {
        logic s1_valid;
        logic s1_ready;
    } blend_stat_t;

    localparam logic [7:0] REG_SKIP_X     = 8'd0;
    localparam logic [7:0] REG_SKIP_Y     = 8'd1;
    localparam logic [7:0] REG_OUT_WIDTH  = 8'd2;
    localparam logic [7:0] REG_OUT_HEIGHT = 8'd3;

    localparam logic [7:0] RST_SKIP_X     = 8'd5;
    localparam logic [7:0] RST_SKIP_Y     = 8'd9;
    localparam logic [7:0] RST_OUT_WIDTH  = 8'd128;
    localparam logic [7:0] RST_OUT_HEIGHT = 8'd128;

    // Advance a drop phase; wrap once phase+1 reaches the period (0 acts as 1).
    function automatic logic [7:0] next_phase(input logic [7:0] phase,
                                              input logic [7:0] skip);
        logic [8:0] sum;
        sum = {1'b0, phase} + 9'd1;
        return (sum >= {1'b0, skip}) ? 8'd0 : sum[7:0];
    endfunction

    function automatic logic [7:0] avg8(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[8:1];
    endfunction

    function automatic rgb_t avg_rgb(input rgb_t a, input rgb_t b);
        rgb_t r;
        r.red   = avg8(a.red, b.red);
        r.green = avg8(a.green, b.green);
        r.blue  = avg8(a.blue, b.blue);
        return r;
    endfunction

endpackage

### sv/skd_line_store.sv
// Previous-row line store with a one-ahead prefetch of the right neighbor.
module skd_line_store #(
    parameter int SRC_WIDTH = 160
) (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [$clog2(SRC_WIDTH)-1:0] wr_addr,
    input  skd_pkg::rgb_t                wr_data,
    input  logic [$clog2(SRC_WIDTH)-1:0] rd_addr,
    output skd_pkg::rgb_t                above,
    output skd_pkg::rgb_t                right
);
    import skd_pkg::*;

    rgb_t mem [SRC_WIDTH];
    rgb_t right_reg;
    rgb_t above_reg;

    // Fetch the entry one column ahead; the one fetched last time is directly above.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
            right_reg    <= mem[rd_addr];
            above_reg    <= right_reg;
        end
    end

    assign above = above_reg;
    assign right = right_reg;

endmodule

### sv/skd_pos_ctrl.sv
// Raster position, drop phases and kept counts; per-pixel blend and emit decisions.
module skd_pos_ctrl #(
    parameter int SRC_WIDTH  = 160,
    parameter int SRC_HEIGHT = 144
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         fire,
    input  logic                         frame_start,
    input  skd_pkg::cfg_t                cfg,
    output skd_pkg::tap_t                tap,
    output logic [$clog2(SRC_WIDTH)-1:0] wr_addr,
    output logic [$clog2(SRC_WIDTH)-1:0] rd_addr
);
    import skd_pkg::*;

    localparam int COL_W = $clog2(SRC_WIDTH);
    localparam int ROW_W = $clog2(SRC_HEIGHT);
    localparam int XC_W  = (COL_W > 8) ? COL_W : 8;
    localparam int YC_W  = (ROW_W > 8) ? ROW_W : 8;
    localparam logic [COL_W:0] LAST_COL = (COL_W + 1)'(SRC_WIDTH - 1);
    localparam logic [ROW_W:0] LAST_ROW = (ROW_W + 1)'(SRC_HEIGHT - 1);

    logic [COL_W-1:0] col_reg, col_next, kc_reg, kc_next;
    logic [ROW_W-1:0] row_reg, row_next, kr_reg, kr_next;
    logic [7:0]       cp_reg, cp_next, rp_reg, rp_next;
    logic             ak_reg, ak_next;

    logic [COL_W-1:0] c, kc;
    logic [ROW_W-1:0] r, kr, my;
    logic [7:0]       cp, rp;
    logic             ak, col_kept, last_col, this_kept, in_bounds;
    logic [COL_W:0]   col_inc;
    logic [XC_W-1:0]  xc;
    logic [YC_W-1:0]  yc;

    always_comb begin
        // Frame start homes the position before this pixel is placed.
        c  = frame_start ? '0 : col_reg;
        r  = frame_start ? '0 : row_reg;
        cp = frame_start ? 8'd0 : cp_reg;
        rp = frame_start ? 8'd0 : rp_reg;
        kc = frame_start ? '0 : kc_reg;
        kr = frame_start ? '0 : kr_reg;
        ak = frame_start ? 1'b0 : ak_reg;

        col_kept  = (c == '0) || (cp != 8'd0);
        col_inc   = {1'b0, c} + (COL_W + 1)'(1);
        last_col  = ({1'b0, c} == LAST_COL);
        my        = kr - ROW_W'(1);
        xc        = XC_W'(kc);
        yc        = YC_W'(my);
        in_bounds = (yc < YC_W'(cfg.out_height)) && (xc < XC_W'(cfg.out_width));

        tap.emit  = (r != '0) && ak && col_kept && in_bounds;
        tap.right = !last_col && ({1'b0, r} > (ROW_W + 1)'(1)) &&
                    (next_phase(cp, cfg.skip_x) == 8'd0);
        tap.down  = (rp == 8'd0) && (c != '0);
        tap.mx    = xc[7:0];
        tap.my    = yc[7:0];

        wr_addr = c;
        rd_addr = last_col ? '0 : col_inc[COL_W-1:0];

        this_kept = (r == '0) || (rp != 8'd0);
        col_next  = last_col ? '0 : col_inc[COL_W-1:0];
        cp_next   = last_col ? 8'd0 : next_phase(cp, cfg.skip_x);
        kc_next   = last_col ? '0 : kc + COL_W'(col_kept);
        row_next  = r;
        rp_next   = rp;
        kr_next   = kr;
        ak_next   = ak;
        if (last_col) begin
            if ({1'b0, r} == LAST_ROW) begin
                row_next = '0;
                rp_next  = 8'd0;
                kr_next  = '0;
                ak_next  = 1'b0;
            end else begin
                row_next = r + ROW_W'(1);
                rp_next  = next_phase(rp, cfg.skip_y);
                kr_next  = kr + ROW_W'(this_kept);
                ak_next  = this_kept;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            cp_reg  <= 8'd0;
            rp_reg  <= 8'd0;
            kc_reg  <= '0;
            kr_reg  <= '0;
            ak_reg  <= 1'b0;
        end else if (fire) begin
            col_reg <= col_next;
            row_reg <= row_next;
            cp_reg  <= cp_next;
            rp_reg  <= rp_next;
            kc_reg  <= kc_next;
            kr_reg  <= kr_next;
            ak_reg  <= ak_next;
        end
    end

endmodule

### sv/skd_blend.sv
// Blend stage register, color averaging and output register.
module skd_blend (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  fire,
    input  skd_pkg::tap_t         tap,
    input  skd_pkg::rgb_t         cur,
    input  skd_pkg::rgb_t         above,
    input  skd_pkg::rgb_t         right,
    input  logic                  m_ready,
    output logic                  m_valid,
    output skd_pkg::pix_out_t     m_data,
    output skd_pkg::blend_stat_t  stat
);
    import skd_pkg::*;

    logic     s1_valid_reg;
    tap_t     s1_tap_reg;
    rgb_t     s1_cur_reg;
    logic     m_valid_reg;
    pix_out_t m_data_reg, m_data_next;
    logic     advance;
    rgb_t     pix_r, pix_d;

    assign advance = s1_valid_reg && (!m_valid_reg || m_ready);

    always_comb begin
        pix_r = s1_tap_reg.right ? avg_rgb(above, right) : above;
        pix_d = s1_tap_reg.down ? avg_rgb(pix_r, s1_cur_reg) : pix_r;
        m_data_next.out_x     = s1_tap_reg.mx;
        m_data_next.out_y     = s1_tap_reg.my;
        m_data_next.out_red   = pix_d.red;
        m_data_next.out_green = pix_d.green;
        m_data_next.out_blue  = pix_d.blue;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (fire) begin
                s1_valid_reg <= tap.emit;
            end else if (advance) begin
                s1_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            s1_tap_reg <= tap;
            s1_cur_reg <= cur;
        end
        if (advance) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_data        = m_data_reg;
    assign stat.s1_valid = s1_valid_reg;
    assign stat.s1_ready = !s1_valid_reg || advance;

endmodule

### sv/skip_blend_downscaler_core.sv
// Top level of the skip-blend downscaler: config registers, handshake and stage wiring.
//
//  channel   ports                             direction  moves
//  -------   -------------------------------   ---------  ---------------------------------
//  s_        s_valid s_ready s_data            in         one source pixel per request
//  m_        m_valid m_ready m_data            out        one matrix pixel per request
//  cfg_      cfg_valid cfg_ready cfg_index     in         one register write per request
//            cfg_data
//
//  One pixel is taken every cycle while s_ready is high; each result passes the blend
//  stage register, loaded beside the line store read, and then the output register.
//  Reset sets the position to the frame origin and the registers to their defaults;
//  the line store is not cleared, the first row fills it before a read result is used.
//  A stalled output holds the blend stage; s_ready drops only while both are full.
module skip_blend_downscaler_core #(
    parameter int SRC_WIDTH  = 160,
    parameter int SRC_HEIGHT = 144
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  skd_pkg::pix_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output skd_pkg::pix_out_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_index,
    input  logic [7:0]        cfg_data
);
    import skd_pkg::*;

    `include "skip_blend_downscaler_core_defines.svh"

    localparam int ADDR_W = $clog2(SRC_WIDTH);

    logic [7:0]  skip_x_reg, skip_y_reg, out_width_reg, out_height_reg;
    cfg_t        cfg;
    tap_t        tap;
    rgb_t        cur, above, right;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    blend_stat_t stat;
    logic        fire;

    // Accept config writes in any cycle; ignore indexes past the register list.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_x_reg     <= RST_SKIP_X;
            skip_y_reg     <= RST_SKIP_Y;
            out_width_reg  <= RST_OUT_WIDTH;
            out_height_reg <= RST_OUT_HEIGHT;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SKIP_X:     skip_x_reg     <= cfg_data;
                REG_SKIP_Y:     skip_y_reg     <= cfg_data;
                REG_OUT_WIDTH:  out_width_reg  <= cfg_data;
                REG_OUT_HEIGHT: out_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.skip_x     = skip_x_reg;
    assign cfg.skip_y     = skip_y_reg;
    assign cfg.out_width  = out_width_reg;
    assign cfg.out_height = out_height_reg;

    // Take a pixel whenever the blend stage is empty or drains this cycle.
    assign s_ready   = stat.s1_ready;
    assign fire      = s_valid && s_ready;
    assign cur.red   = s_data.pix_red;
    assign cur.green = s_data.pix_green;
    assign cur.blue  = s_data.pix_blue;

    // Track the raster position and decide blends and emission per pixel.
    skd_pos_ctrl #(
        .SRC_WIDTH  (SRC_WIDTH),
        .SRC_HEIGHT (SRC_HEIGHT)
    ) u_pos (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .frame_start (s_data.frame_start),
        .cfg         (cfg),
        .tap         (tap),
        .wr_addr     (wr_addr),
        .rd_addr     (rd_addr)
    );

    // Store the arriving pixel and prefetch the next column of the row above.
    skd_line_store #(
        .SRC_WIDTH (SRC_WIDTH)
    ) u_line (
        .aclk    (aclk),
        .wr_en   (fire),
        .wr_addr (wr_addr),
        .wr_data (cur),
        .rd_addr (rd_addr),
        .above   (above),
        .right   (right)
    );

    // Blend with the dropped neighbors and hold the result for the output request.
    skd_blend u_blend (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .tap     (tap),
        .cur     (cur),
        .above   (above),
        .right   (right),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data),
        .stat    (stat)
    );

    // An empty output register must never block the input.
    `SKD_ASSERT_NOW(a_ready_when_empty, !m_valid, s_ready, "input blocked with empty output")
    // A result appears only out of a filled blend stage.
    `SKD_ASSERT_NOW(a_result_from_stage, m_valid && !$past(m_valid), $past(stat.s1_valid), "result without staged pixel")
    // A taken result with nothing staged behind it leaves the output empty.
    `SKD_ASSERT_NEXT(a_drain_empties, m_valid && m_ready && !stat.s1_valid, !m_valid, "result repeated after drain")

endmodule
